// ===== rtl/line_duplicate_word_checker_unit_macros.svh =====
// Assertion macros shared by the duplicate word checker RTL.
// Needs a clk and an active-low rst_n in the including module.
`ifndef LINE_DUPLICATE_WORD_CHECKER_UNIT_MACROS_SVH
`define LINE_DUPLICATE_WORD_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LDWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LDWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ldwc_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// duplicate word checker. No dependencies.
package ldwc_pkg;

  localparam int MAX_WORD_LEN = 19;
  localparam int MAX_WORDS    = 32;

  localparam int LEN_W      = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W      = $clog2(MAX_WORDS + 1);
  localparam int SLOT_W     = $clog2(MAX_WORDS);
  // one spare slot holds a word that finds the line full
  localparam int CHAR_DEPTH = (MAX_WORDS + 1) * MAX_WORD_LEN;
  localparam int ADDR_W     = $clog2(CHAR_DEPTH);

  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef struct packed {
    logic accept_char;
    logic accept_delim;
    logic rd_len;
    logic next_slot;
    logic rd_char;
    logic next_char;
    logic set_dup;
    logic store_word;
    logic emit;
  } ldwc_cmd_t;

  typedef struct packed {
    logic in_delim;
    logic in_nl;
    logic in_word;
    logic nl_pend;
    logic slots_done;
    logic line_ok;
    logic len_eq;
    logic chars_done;
    logic char_eq;
    logic out_free;
  } ldwc_sts_t;

endpackage

// ===== rtl/line_duplicate_word_checker_unit.sv =====
// Flow: a word byte, or a space after a delimiter, is taken in the idle state. A delimiter
// ending a word walks the earlier words of the line slot by slot, compares characters with
// each equal-length earlier word and stores the word; no bytes are taken until this is done,
// and compares stop once the line is bad. A newline adds an emit step; its beat is registered.
// The emit step holds while the previous beat is still untaken; no bytes are taken then.
// Reset: synchronous active-low rst_n clears counters, flags and good-line count.
module line_duplicate_word_checker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] ch
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] line_good, [32:1] good_lines, [33] too_long, [39:34] zero
  output logic [ldwc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ldwc_pkg::*;

  ldwc_cmd_t cmd;
  ldwc_sts_t sts;

  ldwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ldwc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/ldwc_dp.sv =====
// Datapath of the duplicate word checker: word/character memories,
// counters, line flags and the output register. Uses ldwc_pkg and the macro header.
`include "line_duplicate_word_checker_unit_macros.svh"

module ldwc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [7:0]                         in_ch,
  input  ldwc_pkg::ldwc_cmd_t                cmd,
  output ldwc_pkg::ldwc_sts_t                sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ldwc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ldwc_pkg::*;

  logic [7:0]        char_mem [CHAR_DEPTH];
  logic [LEN_W-1:0]  len_mem  [MAX_WORDS];

  logic [LEN_W-1:0]  word_len_r;
  logic [CNT_W-1:0]  words_r;
  logic [ADDR_W-1:0] cur_base_r;
  logic [CNT_W-1:0]  slot_r;
  logic [ADDR_W-1:0] cmp_base_r;
  logic [LEN_W-1:0]  idx_r;
  logic              in_word_r;
  logic              nl_pend_r;
  logic              line_ok_r;
  logic              ovf_r;
  logic [31:0]       total_r;
  logic              out_valid_r;
  logic              out_good_r;
  logic              out_ovf_r;
  logic [7:0]        qa_r;
  logic [7:0]        qb_r;
  logic [LEN_W-1:0]  len_q_r;

  logic              word_room;
  logic              slot_room;
  logic              line_good;

  assign word_room = word_len_r < LEN_W'(MAX_WORD_LEN);
  assign slot_room = words_r < CNT_W'(MAX_WORDS);
  assign line_good = line_ok_r & ~ovf_r;

  // character store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.accept_char && word_room) begin
      char_mem[cur_base_r + ADDR_W'(word_len_r)] <= in_ch;
    end
    if (cmd.rd_char) begin
      qa_r <= char_mem[cmp_base_r + ADDR_W'(idx_r)];
      qb_r <= char_mem[cur_base_r + ADDR_W'(idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_word && slot_room) begin
      len_mem[words_r[SLOT_W-1:0]] <= word_len_r;
    end
    if (cmd.rd_len) begin
      len_q_r <= len_mem[slot_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_len_r  <= '0;
      words_r     <= '0;
      cur_base_r  <= '0;
      slot_r      <= '0;
      cmp_base_r  <= '0;
      idx_r       <= '0;
      in_word_r   <= 1'b1;
      nl_pend_r   <= 1'b0;
      line_ok_r   <= 1'b1;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept_char) begin
        in_word_r <= 1'b1;
        if (word_room) begin
          word_len_r <= word_len_r + LEN_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.accept_delim) begin
        in_word_r  <= 1'b0;
        nl_pend_r  <= sts.in_nl;
        slot_r     <= '0;
        cmp_base_r <= '0;
        // an empty word counts as a duplicate
        if (in_word_r && word_len_r == '0) begin
          line_ok_r <= 1'b0;
        end
      end
      if (cmd.rd_len) begin
        idx_r <= '0;
      end
      if (cmd.next_char) begin
        idx_r <= idx_r + LEN_W'(1);
      end
      if (cmd.next_slot) begin
        slot_r     <= slot_r + CNT_W'(1);
        cmp_base_r <= cmp_base_r + ADDR_W'(MAX_WORD_LEN);
      end
      if (cmd.set_dup) begin
        line_ok_r <= 1'b0;
      end
      if (cmd.store_word) begin
        word_len_r <= '0;
        if (slot_room) begin
          words_r    <= words_r + CNT_W'(1);
          cur_base_r <= cur_base_r + ADDR_W'(MAX_WORD_LEN);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_good_r  <= line_good;
        out_ovf_r   <= ovf_r;
        if (line_good) begin
          total_r <= total_r + 32'd1;
        end
        word_len_r <= '0;
        words_r    <= '0;
        cur_base_r <= '0;
        in_word_r  <= 1'b1;
        line_ok_r  <= 1'b1;
        ovf_r      <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.in_delim   = (in_ch == CH_SPACE) || (in_ch == CH_NEWLINE);
    sts.in_nl      = (in_ch == CH_NEWLINE);
    sts.in_word    = in_word_r;
    sts.nl_pend    = nl_pend_r;
    sts.slots_done = (slot_r == words_r);
    sts.line_ok    = line_ok_r;
    sts.len_eq     = (len_q_r == word_len_r);
    sts.chars_done = (idx_r == word_len_r);
    sts.char_eq    = (qa_r == qb_r);
    sts.out_free   = ~out_valid_r | out_tready;
  end

  // total only moves at emit, which waits for a free output, so it is stable here
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 34){1'b0}}, out_ovf_r, total_r, out_good_r};

  `LDWC_ASSERT_NOW(a_word_len_cap, 1'b1, word_len_r <= LEN_W'(MAX_WORD_LEN), "word length over cap")
  `LDWC_ASSERT_NOW(a_words_cap, 1'b1, words_r <= CNT_W'(MAX_WORDS), "word count over cap")
  `LDWC_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_r || out_tready, "emit over a held beat")
  `LDWC_ASSERT_NEXT(a_emit_clears, cmd.emit, words_r == '0 && line_ok_r && out_valid_r,
                    "line not cleared after emit")

endmodule

// ===== rtl/ldwc_ctrl.sv =====
// Controller state machine of the duplicate word checker: sequences
// byte intake, slot-by-slot word compares, store and emit. Uses ldwc_pkg.
module ldwc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ldwc_pkg::ldwc_sts_t  sts,
  output ldwc_pkg::ldwc_cmd_t  cmd
);
  import ldwc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_LEN,
    S_CH_RD,
    S_CH_CMP,
    S_STORE,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!sts.in_delim) begin
            cmd.accept_char = 1'b1;
          end else begin
            cmd.accept_delim = 1'b1;
            if (sts.in_word) begin
              state_nxt = S_SLOT;
            end else if (sts.in_nl) begin
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_SLOT: begin
        // a bad line cannot get worse: skip straight to store
        if (sts.slots_done || !sts.line_ok) begin
          state_nxt = S_STORE;
        end else begin
          cmd.rd_len = 1'b1;
          state_nxt  = S_LEN;
        end
      end
      S_LEN: begin
        if (sts.len_eq) begin
          state_nxt = S_CH_RD;
        end else begin
          cmd.next_slot = 1'b1;
          state_nxt     = S_SLOT;
        end
      end
      S_CH_RD: begin
        if (sts.chars_done) begin
          cmd.set_dup   = 1'b1;
          cmd.next_slot = 1'b1;
          state_nxt     = S_SLOT;
        end else begin
          cmd.rd_char = 1'b1;
          state_nxt   = S_CH_CMP;
        end
      end
      S_CH_CMP: begin
        if (sts.char_eq) begin
          cmd.next_char = 1'b1;
          state_nxt     = S_CH_RD;
        end else begin
          cmd.next_slot = 1'b1;
          state_nxt     = S_SLOT;
        end
      end
      S_STORE: begin
        cmd.store_word = 1'b1;
        state_nxt      = sts.nl_pend ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ===== verif/tb_line_duplicate_word_checker_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_duplicate_word_checker_unit: drives text bytes on the
// in_ stream, predicts each line verdict in-bench and checks every out_ beat.
// Depends on ldwc_pkg and the unit's RTL only.
module tb_line_duplicate_word_checker_unit;
  import ldwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2000;
  localparam int RANDOM_TARGET  = 1150;
  localparam int FINAL_TARGET   = 1650;

  typedef struct {
    logic        line_good;
    logic [31:0] good_lines;
    logic        too_long;
  } line_verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;    // [7:0] ch
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] line_good, [32:1] good_lines, [33] too_long

  // Line state of the predictor
  logic [7:0]  cur_word [MAX_WORD_LEN];
  int          cur_len = 0;
  logic [7:0]  kept_word [MAX_WORDS][MAX_WORD_LEN];
  int          kept_len [MAX_WORDS];
  int          kept_count = 0;
  bit          mid_word = 1'b1;
  bit          line_clean = 1'b1;
  bit          line_overflow = 1'b0;
  logic [31:0] good_count = '0;

  line_verdict_t verdicts_due [$];

  bit in_gaps = 1'b0;
  bit out_gaps = 1'b0;
  int hold_len = 0;
  int idle_cycles = 0;
  int errors = 0;
  int bytes_sent = 0;
  int lines_seen = 0;
  int good_seen = 0;
  int overfull_seen = 0;
  int in_stall_cycles = 0;

  line_duplicate_word_checker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void open_line();
    cur_len = 0;
    kept_count = 0;
    mid_word = 1'b1;
    line_clean = 1'b1;
    line_overflow = 1'b0;
  endfunction

  function automatic void close_word();
    bit same;
    if (cur_len == 0) line_clean = 1'b0;
    for (int w = 0; w < kept_count; w++) begin
      same = (kept_len[w] == cur_len);
      for (int i = 0; i < cur_len; i++) begin
        if (kept_word[w][i] != cur_word[i]) same = 1'b0;
      end
      if (same) line_clean = 1'b0;
    end
    // a word that finds every slot taken is compared but not kept
    if (kept_count < MAX_WORDS) begin
      for (int i = 0; i < cur_len; i++) kept_word[kept_count][i] = cur_word[i];
      kept_len[kept_count] = cur_len;
      kept_count++;
    end else begin
      line_overflow = 1'b1;
    end
    cur_len = 0;
  endfunction

  function automatic void take_byte(input logic [7:0] ch);
    line_verdict_t v;
    if (ch != CH_SPACE && ch != CH_NEWLINE) begin
      // drop bytes past the word capacity
      if (cur_len < MAX_WORD_LEN) begin
        cur_word[cur_len] = ch;
        cur_len++;
      end else begin
        line_overflow = 1'b1;
      end
      mid_word = 1'b1;
    end else begin
      if (mid_word) close_word();
      mid_word = 1'b0;
      if (ch == CH_NEWLINE) begin
        v.line_good = line_clean && !line_overflow;
        if (v.line_good) good_count = good_count + 32'd1;
        v.good_lines = good_count;
        v.too_long = line_overflow;
        verdicts_due.push_back(v);
        open_line();
      end
    end
  endfunction

  task automatic push_byte(input logic [7:0] b);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    take_byte(b);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) begin
      b = 8'h61 + 8'($urandom_range(0, 2));
    end else begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_NEWLINE);
    end
    return b;
  endfunction

  // Words are fresh or copies of an earlier word of the line, so repeats are common.
  task automatic send_random_line(input int max_words, input int max_len);
    logic [7:0] lw [64][32];
    int lw_len [64];
    int n;
    int pick;
    n = $urandom_range(0, max_words);
    if ($urandom_range(0, 7) == 0) push_byte(CH_SPACE);
    for (int w = 0; w < n; w++) begin
      if (w > 0 && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, w - 1);
        lw_len[w] = lw_len[pick];
        for (int i = 0; i < lw_len[pick]; i++) lw[w][i] = lw[pick][i];
      end else begin
        lw_len[w] = $urandom_range(1, max_len);
        for (int i = 0; i < lw_len[w]; i++) lw[w][i] = word_byte();
      end
      for (int i = 0; i < lw_len[w]; i++) push_byte(lw[w][i]);
      if (w < n - 1 || $urandom_range(0, 3) == 0) begin
        push_byte(CH_SPACE);
        if ($urandom_range(0, 5) == 0) push_byte(CH_SPACE);
      end
    end
    push_byte(CH_NEWLINE);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       b = CH_NEWLINE;
        1:       b = CH_SPACE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b);
    end
  endtask

  task automatic send_mixed(input int target);
    int pick;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 82)      send_random_line(6, 4);
      else if (pick < 88) send_random_line(3, 26);
      else if (pick < 91) send_random_line(40, 2);
      else                send_noise($urandom_range(1, 12));
    end
    push_byte(CH_NEWLINE);
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Score each out beat against the oldest pending verdict; watch for a hang.
  always @(posedge clk) begin
    line_verdict_t v;
    if (rst_n) begin
      if (in_tvalid && !in_tready) in_stall_cycles++;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_tvalid && out_tready) begin
        lines_seen++;
        if (out_tdata[0]) good_seen++;
        if (out_tdata[33]) overfull_seen++;
        if (verdicts_due.size() == 0) begin
          report_mismatch("beat with no line pending", 40'(out_tdata), '0);
        end else begin
          v = verdicts_due.pop_front();
          if (out_tdata[0] !== v.line_good)
            report_mismatch("line_good", 40'(out_tdata[0]), 40'(v.line_good));
          if (out_tdata[32:1] !== v.good_lines)
            report_mismatch("good_lines", 40'(out_tdata[32:1]), 40'(v.good_lines));
          if (out_tdata[33] !== v.too_long)
            report_mismatch("too_long", 40'(out_tdata[33]), 40'(v.too_long));
          if (out_tdata[39:34] !== '0)
            report_mismatch("pad bits", 40'(out_tdata[39:34]), '0);
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles, %0d lines pending",
                 idle_cycles, verdicts_due.size());
        $display("line_duplicate_word_checker_unit: mismatch");
        $finish;
      end
    end
  end

  // Receiver ready: long hold-off on request, else random stall bursts while out_gaps is set.
  initial begin : sink_ready
    int n;
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (out_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_directed();
    push_byte(CH_NEWLINE);          // empty line
    push_text(" x\n");              // leading space ends an empty word
    push_text("ab ab\n");           // repeated word
    push_text("ab  cd \n");         // runs of delimiters end one word
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_SPACE);
    push_byte(8'hFF);
    push_byte(CH_NEWLINE);
  endtask

  task automatic test_capacity();
    // over-long word, then a line with one word more than fits
    for (int i = 0; i < MAX_WORD_LEN + 2; i++) push_byte(8'h6B);
    push_byte(CH_NEWLINE);
    for (int w = 0; w <= MAX_WORDS; w++) begin
      push_byte(8'h41 + 8'(w / 26));
      push_byte(8'h61 + 8'(w % 26));
      push_byte(w == MAX_WORDS ? CH_NEWLINE : CH_SPACE);
    end
  endtask

  task automatic test_random_traffic();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    send_mixed(RANDOM_TARGET);
  endtask

  task automatic test_fill_and_stall();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_len = 400;
    for (int i = 0; i < 12; i++) push_text("ab\n");
    pause_until_drained();
  endtask

  task automatic test_final_stream();
    send_mixed(FINAL_TARGET);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    open_line();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_random_traffic();
    test_fill_and_stall();
    test_final_stream();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d bytes; checked %0d lines, %0d good and %0d over capacity",
             bytes_sent, lines_seen, good_seen, overfull_seen);
    $display("empty, repeated, over-long and over-full lines, noise; input held %0d cycles",
             in_stall_cycles);
    if (errors == 0) begin
      $display("line_duplicate_word_checker_unit: match");
    end else begin
      $display("line_duplicate_word_checker_unit: mismatch");
    end
    $finish;
  end

endmodule
